@@ rtl/ptbl_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ptbl_pkg - shared types and constants for the peer table
// Request and result structs, table entry layout, status codes and widths.
// ============================================================================
package ptbl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ECNT_W      = 7;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    typedef enum logic [2:0] {
        STS_ADDED     = 3'd0,
        STS_UPDATED   = 3'd1,
        STS_REMOVED   = 3'd2,
        STS_FOUND     = 3'd3,
        STS_NOT_FOUND = 3'd4,
        STS_SELF      = 3'd5,
        STS_FULL      = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] peer_id;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] peer_port;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [63:0]        found_addr_high;
        logic [63:0]        found_addr_low;
        logic [15:0]        found_port;
        logic [ECNT_W-1:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic [15:0] id;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Low bits of the entry count as reported on the result.
    function automatic logic [ECNT_W-1:0] count_out(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[ECNT_W-1:0];
    endfunction

endpackage

@@ rtl/ptbl_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ptbl_ram - simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ============================================================================
module ptbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/peer_table_add_remove_find.sv @@
`timescale 1ns / 1ps
// ============================================================================
// peer_table_add_remove_find - unordered peer table with add, remove, find
// Linear search by id over one entry RAM; remove moves the last entry into
// the freed slot; slot 0 (self) cannot be overwritten by add.
// ============================================================================
//
//  channel   | handshake           | payload            | direction
//  ----------+---------------------+--------------------+----------
//  request   | start / busy        | i_req  (t_req)     | in
//  result    | o_done (1-cycle)    | o_rsp  (t_rsp)     | out
//
// A request is taken on a clock edge with start high and busy low.
// The id search reads one entry per cycle from the entry RAM (read port is
// the limit): a hit ends the search at that slot, while a miss reads every
// valid entry before the result strobe is raised, count being the number of
// valid entries.
// busy drops with the strobe, or in the cycle after it when a remove has to
// move the last entry down.
// Synchronous active-low reset empties the table at once; RAM contents are
// left as is, only data from slots below the count is ever used.
// The result is shown for one cycle only; the receiver cannot stall it.
//
module peer_table_add_remove_find (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ptbl_pkg::t_req i_req,
    output logic          o_done,
    output ptbl_pkg::t_rsp o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_MOVE
    } t_state;

    localparam int IW = ptbl_pkg::IDX_W;
    localparam int CW = ptbl_pkg::CNT_W;

    t_state                 r_state;
    ptbl_pkg::t_req         r_req;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_ra;        // next slot to read during scan
    logic [IW-1:0]          r_ca;        // slot whose data is on the RAM output
    logic                   r_pend;      // RAM output holds a scanned slot
    logic                   r_hit;
    logic [IW-1:0]          r_hit_idx;
    ptbl_pkg::t_entry       r_hit_ent;
    logic                   r_done;
    ptbl_pkg::t_rsp         r_rsp;

    ptbl_pkg::t_entry       w_rd;
    logic [ptbl_pkg::ENTRY_W-1:0] w_rdata;
    logic                   w_we;
    logic [IW-1:0]          w_waddr;
    ptbl_pkg::t_entry       w_wdata;
    logic [IW-1:0]          w_raddr;
    logic [CW-1:0]          w_last;
    logic                   w_full;
    logic                   w_move;
    logic                   w_id_eq;

    assign w_rd    = ptbl_pkg::t_entry'(w_rdata);
    assign w_last  = r_count - CW'(1);
    assign w_full  = (r_count >= CW'(ptbl_pkg::TABLE_DEPTH));
    // a remove that does not hit the last slot must pull the last entry down
    assign w_move  = r_hit && (CW'(r_hit_idx) < w_last);
    assign w_id_eq = (w_rd.id == r_req.peer_id);

    // Read address: scan pointer while searching, last slot when deciding.
    assign w_raddr = (r_state == S_ACT) ? w_last[IW-1:0] : r_ra[IW-1:0];

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_hit_idx;
        w_wdata = '{id: r_req.peer_id, addr_high: r_req.addr_high,
                    addr_low: r_req.addr_low, port: r_req.peer_port};
        case (r_state)
            S_ACT: begin
                if (r_req.opcode == ptbl_pkg::OP_ADD) begin
                    if (r_hit) begin
                        w_we = (r_hit_idx != '0);
                    end else if (!w_full) begin
                        w_we    = 1'b1;
                        w_waddr = r_count[IW-1:0];
                    end
                end
            end
            S_MOVE: begin
                // RAM output now carries the last entry
                w_we    = 1'b1;
                w_wdata = w_rd;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    ptbl_ram #(
        .WIDTH (ptbl_pkg::ENTRY_W),
        .DEPTH (ptbl_pkg::TABLE_DEPTH),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req   <= i_req;
                        r_ra    <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_pend && w_id_eq) begin
                        // first match wins
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_ca;
                        r_hit_ent <= w_rd;
                        r_pend    <= 1'b0;
                        r_state   <= S_ACT;
                    end else if (!r_pend && (r_ra >= r_count)) begin
                        r_hit   <= 1'b0;
                        r_state <= S_ACT;
                    end else if (r_ra < r_count) begin
                        r_ca   <= r_ra[IW-1:0];
                        r_ra   <= r_ra + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                S_ACT: begin
                    r_done                <= 1'b1;
                    r_rsp.status          <= ptbl_pkg::STS_NOT_FOUND;
                    r_rsp.found_addr_high <= '0;
                    r_rsp.found_addr_low  <= '0;
                    r_rsp.found_port      <= '0;
                    r_rsp.entry_count     <= ptbl_pkg::count_out(r_count);
                    r_state               <= S_IDLE;
                    case (r_req.opcode)
                        ptbl_pkg::OP_ADD: begin
                            if (r_hit && (r_hit_idx == '0)) begin
                                r_rsp.status <= ptbl_pkg::STS_SELF;
                            end else if (r_hit) begin
                                r_rsp.status <= ptbl_pkg::STS_UPDATED;
                            end else if (w_full) begin
                                r_rsp.status <= ptbl_pkg::STS_FULL;
                            end else begin
                                r_count           <= r_count + CW'(1);
                                r_rsp.entry_count <=
                                    ptbl_pkg::count_out(r_count + CW'(1));
                                r_rsp.status      <= ptbl_pkg::STS_ADDED;
                            end
                        end
                        ptbl_pkg::OP_REMOVE: begin
                            if (r_hit) begin
                                r_count           <= w_last;
                                r_rsp.entry_count <= ptbl_pkg::count_out(w_last);
                                r_rsp.status      <= ptbl_pkg::STS_REMOVED;
                                if (w_move) begin
                                    r_state <= S_MOVE;
                                end
                            end
                        end
                        ptbl_pkg::OP_FIND: begin
                            if (r_hit) begin
                                r_rsp.status          <= ptbl_pkg::STS_FOUND;
                                r_rsp.found_addr_high <= r_hit_ent.addr_high;
                                r_rsp.found_addr_low  <= r_hit_ent.addr_low;
                                r_rsp.found_port      <= r_hit_ent.port;
                            end
                        end
                        default: begin
                            r_rsp.status <= ptbl_pkg::STS_NOT_FOUND;
                        end
                    endcase
                end
                S_MOVE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
